// ===== src/parse_integer_text_defines.svh =====
// Assertion macros shared by the parse_integer_text RTL.
// Depends on nothing; files that check their own logic include it by name.
`ifndef PARSE_INTEGER_TEXT_DEFINES_SVH
`define PARSE_INTEGER_TEXT_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising clock edge out of reset.
`define PIT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked at every rising clock edge out of reset.
`define PIT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PIT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PIT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/pit_pkg.sv =====
// Package for the text-to-integer parser: phase and status codes, register map,
// character constants and the shared structs. Depends on nothing.
package pit_pkg;

	// Parse phases.
	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_LEAD   = 3'd1,
		PH_SIGN   = 3'd2,
		PH_ZERO   = 3'd3,
		PH_DIGITS = 3'd4
	} phase_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_PREFIX = 2'd1,
		ST_RANGE      = 2'd2
	} status_t;

	// Configuration register map: index is paddr[2].
	localparam int  PADDR_W         = 3;
	localparam int  PDATA_W         = 32;
	localparam logic REG_NUMBER_BASE = 1'b0;
	localparam logic REG_SIGNED_MODE = 1'b1;

	// Radix constants.
	localparam logic [4:0] BASE_AUTO = 5'd0;
	localparam logic [4:0] BASE_OCT  = 5'd8;
	localparam logic [4:0] BASE_DEC  = 5'd10;
	localparam logic [4:0] BASE_HEX  = 5'd16;

	// Character codes.
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LX    = 8'h78;

	// Live configuration seen by the parser.
	typedef struct packed {
		logic [4:0] number_base;
		logic       signed_mode;
	} cfg_t;

	// Classification of one character.
	typedef struct packed {
		logic       is_blank;
		logic       is_plus;
		logic       is_minus;
		logic       is_zero;
		logic       is_x;
		logic       is_hex;
		logic [3:0] digit_val;
	} char_class_t;

endpackage

// ===== src/pit_regs.sv =====
// APB-style configuration registers of the parser (number base, signed mode).
// Depends on pit_pkg.
module pit_regs
	import pit_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic       wr_en;
	logic [4:0] number_base_q;
	logic       signed_mode_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= BASE_AUTO;
			signed_mode_q <= 1'b1;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_NUMBER_BASE: number_base_q <= pwdata[4:0];
				REG_SIGNED_MODE: signed_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read mux.
	always_comb begin
		unique case (paddr[2])
			REG_NUMBER_BASE: prdata = {{(PDATA_W-5){1'b0}}, number_base_q};
			REG_SIGNED_MODE: prdata = {{(PDATA_W-1){1'b0}}, signed_mode_q};
			default:         prdata = '0;
		endcase
	end

	assign cfg.number_base = number_base_q;
	assign cfg.signed_mode = signed_mode_q;

endmodule

// ===== src/pit_classify.sv =====
// Character classifier: white space, sign, zero, x, and hex digit value.
// Depends on pit_pkg.
module pit_classify
	import pit_pkg::*;
(
	input  logic [7:0]  ch,
	output char_class_t cls
);

	logic is_dec;
	logic is_upper;
	logic is_lower;

	// Digit ranges.
	assign is_dec   = (ch >= CH_0)  && (ch <= CH_9);
	assign is_upper = (ch >= CH_UA) && (ch <= CH_UF);
	assign is_lower = (ch >= CH_LA) && (ch <= CH_LF);

	// Flags and digit value.
	always_comb begin
		cls.is_blank = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
		cls.is_plus  = (ch == CH_PLUS);
		cls.is_minus = (ch == CH_MINUS);
		cls.is_zero  = (ch == CH_0);
		cls.is_x     = (ch == CH_LX) || (ch == CH_UX);
		cls.is_hex   = is_dec | is_upper | is_lower;
		priority if (is_dec) begin
			cls.digit_val = 4'(ch - CH_0);
		end else if (is_upper) begin
			cls.digit_val = 4'(ch - CH_UA + 8'd10);
		end else if (is_lower) begin
			cls.digit_val = 4'(ch - CH_LA + 8'd10);
		end else begin
			cls.digit_val = 4'd0;
		end
	end

endmodule

// ===== src/pit_core.sv =====
// Parse state, one-character step logic and the result register.
// Depends on pit_pkg; takes the character class from pit_classify.
module pit_core
	import pit_pkg::*;
#(
	parameter int VALUE_WIDTH  = 32,
	parameter int OFFSET_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    step,
	input  logic                    first_s1,
	input  char_class_t             cls,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic [VALUE_WIDTH-1:0]  value_out,
	output logic [OFFSET_WIDTH-1:0] end_offset,
	output logic [1:0]              status
);

	localparam int PW = VALUE_WIDTH + 6;
	localparam logic [VALUE_WIDTH-1:0] SIGN_BIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam logic [VALUE_WIDTH-1:0] SMAX     = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic [VALUE_WIDTH-1:0] UMAX     = {VALUE_WIDTH{1'b1}};

	phase_t                  phase_q, phase_eff, phase_nxt;
	logic [VALUE_WIDTH-1:0]  acc_q, acc_eff, acc_nxt;
	logic                    neg_q, neg_eff, neg_nxt;
	logic [4:0]              base_q, base_eff, base_nxt, base_sel;
	logic [OFFSET_WIDTH-1:0] cnt_q, cnt_eff;
	logic                    start_path, bad_prefix, eval, dig_ok, ovf, emit;
	logic [VALUE_WIDTH-1:0]  limit, res_value;
	logic [OFFSET_WIDTH-1:0] res_offset;
	status_t                 res_status;
	logic [PW-1:0]           prod;
	logic                    out_valid_q;
	logic [VALUE_WIDTH-1:0]  value_q;
	logic [OFFSET_WIDTH-1:0] offset_q;
	status_t                 status_q;

	// A first flag restarts the string; otherwise the offset advances unless idle.
	always_comb begin
		if (first_s1) begin
			phase_eff = PH_LEAD;
			acc_eff   = '0;
			neg_eff   = 1'b0;
			base_eff  = '0;
			cnt_eff   = '0;
		end else begin
			phase_eff = phase_q;
			acc_eff   = acc_q;
			neg_eff   = neg_q;
			base_eff  = base_q;
			cnt_eff   = (phase_q == PH_IDLE) ? cnt_q
				: cnt_q + {{(OFFSET_WIDTH-1){1'b0}}, 1'b1};
		end
	end

	// Which path the character takes in this phase.
	assign start_path = ((phase_eff == PH_LEAD) && !cls.is_blank && !cls.is_plus
		&& !cls.is_minus) || (phase_eff == PH_SIGN);
	assign bad_prefix = (phase_eff == PH_ZERO) && cls.is_x
		&& (cfg.number_base != BASE_AUTO) && (cfg.number_base != BASE_HEX);
	assign eval = (start_path && !cls.is_zero) || ((phase_eff == PH_ZERO) && !cls.is_x)
		|| (phase_eff == PH_DIGITS);

	// Radix used by the digit test of this character.
	always_comb begin
		unique case (phase_eff)
			PH_LEAD, PH_SIGN: base_sel = (cfg.number_base == BASE_AUTO) ? BASE_DEC
				: cfg.number_base;
			PH_ZERO:          base_sel = (cfg.number_base == BASE_AUTO) ? BASE_OCT
				: cfg.number_base;
			default:          base_sel = base_eff;
		endcase
	end

	// Digit test, multiply-accumulate and exact range check.
	assign dig_ok = cls.is_hex && ({1'b0, cls.digit_val} < base_sel);
	assign limit  = cfg.signed_mode ? (neg_eff ? SIGN_BIT : SMAX) : UMAX;
	assign prod   = PW'(acc_eff) * PW'(base_sel) + PW'(cls.digit_val);
	assign ovf    = prod > PW'(limit);
	assign emit   = step && (bad_prefix || (eval && (!dig_ok || ovf)));

	// Next parse state.
	always_comb begin
		phase_nxt = phase_eff;
		acc_nxt   = acc_eff;
		neg_nxt   = neg_eff;
		base_nxt  = base_eff;
		unique case (phase_eff)
			PH_LEAD: begin
				if (cls.is_plus || cls.is_minus) begin
					neg_nxt   = cls.is_minus & cfg.signed_mode;
					phase_nxt = PH_SIGN;
				end
			end
			PH_ZERO: begin
				if (cls.is_x) begin
					base_nxt  = BASE_HEX;
					phase_nxt = PH_DIGITS;
				end
			end
			default: ;
		endcase
		if (start_path && cls.is_zero) begin
			phase_nxt = PH_ZERO;
		end
		if (eval) begin
			base_nxt  = base_sel;
			phase_nxt = PH_DIGITS;
			acc_nxt   = prod[VALUE_WIDTH-1:0];
		end
		if (emit) begin
			phase_nxt = PH_IDLE;
		end
	end

	// Result of an ending character.
	always_comb begin
		priority if (bad_prefix) begin
			res_value  = '0;
			res_offset = '0;
			res_status = ST_BAD_PREFIX;
		end else if (!dig_ok) begin
			res_value  = neg_eff ? ({VALUE_WIDTH{1'b0}} - acc_eff) : acc_eff;
			res_offset = cnt_eff;
			res_status = ST_OK;
		end else begin
			res_value  = (cfg.signed_mode && neg_eff) ? SIGN_BIT : limit;
			res_offset = '0;
			res_status = ST_RANGE;
		end
	end

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			base_q  <= '0;
			cnt_q   <= '0;
		end else if (step) begin
			phase_q <= phase_nxt;
			acc_q   <= acc_nxt;
			neg_q   <= neg_nxt;
			base_q  <= base_nxt;
			cnt_q   <= cnt_eff;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			value_q  <= res_value;
			offset_q <= res_offset;
			status_q <= res_status;
		end
	end

	assign out_valid  = out_valid_q;
	assign value_out  = value_q;
	assign end_offset = offset_q;
	assign status     = status_q;

endmodule

// ===== src/parse_integer_text.sv =====
// Channel   Handshake            Payload
// in        in_valid/in_ready    char_in[7:0], first_char
// out       out_valid/out_ready  value_out, end_offset, status[1:0]
// cfg       psel/penable/pready  paddr, pwdata, prdata (number_base, signed_mode)
// One character per cycle unless a held result stalls the step: it is staged in the input
// register, then the step logic (one small multiply by the radix plus an add and compare)
// updates the parse state and loads the result register in the same cycle.
// The result of an ending character passes the input register, then the result register.
// A result held by out_ready low stalls the step of any waiting character, and so in_ready.
// Reset clears the parse to idle; characters are ignored until a first flag.
// Top level of the text-to-integer parser; depends on pit_pkg, pit_regs,
// pit_classify, pit_core and parse_integer_text_defines.svh.
`include "parse_integer_text_defines.svh"
module parse_integer_text
	import pit_pkg::*;
#(
	parameter int VALUE_WIDTH  = 32,
	parameter int OFFSET_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [PADDR_W-1:0]      paddr,
	input  logic [PDATA_W-1:0]      pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              char_in,
	input  logic                    first_char,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [VALUE_WIDTH-1:0]  value_out,
	output logic [OFFSET_WIDTH-1:0] end_offset,
	output logic [1:0]              status
);

	cfg_t        cfg;
	char_class_t cls;
	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        first_s1;
	logic        step;

	// The step runs when an item is staged and the result register can take one.
	assign step     = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || step;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1  <= char_in;
			first_s1 <= first_char;
		end
	end

	pit_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pit_classify u_classify (
		.ch  (char_s1),
		.cls (cls)
	);

	pit_core #(
		.VALUE_WIDTH  (VALUE_WIDTH),
		.OFFSET_WIDTH (OFFSET_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.step       (step),
		.first_s1   (first_s1),
		.cls        (cls),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.value_out  (value_out),
		.end_offset (end_offset),
		.status     (status)
	);

	// Checks on the step control and the result codes.
	`PIT_ASSERT_IMP(a_no_take_when_blocked, clk, arst_n, valid_s1 && out_valid && !out_ready, !in_ready, "item taken while input register and result are both blocked")
	`PIT_ASSERT_NXT(a_result_from_step, clk, arst_n, !out_valid && !step, !out_valid, "result appeared without a parse step")
	`PIT_ASSERT_IMP(a_range_offset_zero, clk, arst_n, out_valid && (status == ST_RANGE), end_offset == '0, "range error with nonzero offset")
	`PIT_ASSERT_IMP(a_bad_prefix_zero, clk, arst_n, out_valid && (status == ST_BAD_PREFIX), (value_out == '0) && (end_offset == '0), "bad prefix result not zero")

endmodule

// ===== test/tb_parse_integer_text.sv =====
// Self-checking testbench for parse_integer_text: directed strings, then random
// text under four pacing modes and many radix settings; needs pit_pkg and the DUT.
module tb_parse_integer_text;
	import pit_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int VAL_W          = 32;
	localparam int OFF_W          = 32;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS   = 1500;
	localparam int RANDOM_PHASES  = 12;
	localparam int unsigned NOT_A_DIGIT = 32;

	// Pacing per mode: sender idle and receiver stall, in percent.
	localparam int unsigned SEND_IDLE[4]  = '{0, 84, 0, 18};
	localparam int unsigned RECV_STALL[4] = '{0, 0, 84, 18};
	// Register settings for the random phases, three per pacing mode.
	localparam logic [4:0] RAND_BASES[RANDOM_PHASES] = '{
		BASE_AUTO, BASE_DEC, BASE_HEX, 5'd2, BASE_OCT, 5'd31,
		5'd1, BASE_AUTO, BASE_HEX, BASE_DEC, 5'd7, 5'd20};
	localparam bit RAND_SIGNED[RANDOM_PHASES] = '{1, 0, 1, 0, 1, 0, 1, 0, 0, 1, 1, 0};

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [OFF_W-1:0] offset;
		status_t          status;
	} parse_result_t;

	// One queued item plus the typed result of its string, if any.
	typedef struct {
		logic [7:0]    ch;
		bit            first;
		bit            typed;
		parse_result_t want;
	} text_byte_t;

	typedef struct {
		string      chars;
		logic [7:0] tail;
		logic [4:0] base;
		bit         sgn;
		bit         restart;
		bit         typed;
		logic [31:0] value;
		logic [31:0] offset;
		status_t    status;
	} directed_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [PADDR_W-1:0]      paddr = '0;
	logic [PDATA_W-1:0]      pwdata = '0;
	logic [PDATA_W-1:0]      prdata;
	logic                    pready;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [7:0]              char_in = '0;
	logic                    first_char = 1'b0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [VAL_W-1:0]        value_out;
	logic [OFF_W-1:0]        end_offset;
	logic [1:0]              status;

	// Parser state and register copy kept by the predictor.
	phase_t      phase = PH_IDLE;
	logic [31:0] acc = '0;
	bit          neg = 1'b0;
	int unsigned ebase = 0;
	logic [31:0] count = '0;
	logic [4:0]  cfg_base = BASE_AUTO;
	bit          cfg_signed = 1'b1;

	text_byte_t    char_queue[$];
	parse_result_t expected_results[$];
	directed_row_t directed_rows[$];
	text_byte_t    cur_byte;
	bit            in_taken = 1'b0;
	bit            typed_pending = 1'b0;
	parse_result_t typed_result;
	int unsigned   send_idle_pct = 0;
	int unsigned   recv_stall_pct = 0;
	int unsigned   idle_cycles = 0;
	int unsigned   fail_count = 0;
	int unsigned   items_accepted = 0;
	int unsigned   results_checked = 0;
	int unsigned   config_writes = 0;

	parse_integer_text #(
		.VALUE_WIDTH (VAL_W),
		.OFFSET_WIDTH(OFF_W)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_in   (char_in),
		.first_char(first_char),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value_out (value_out),
		.end_offset(end_offset),
		.status    (status)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Character classes of the parser.
	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic int unsigned digit_value(input logic [7:0] c);
		if (c >= CH_0 && c <= CH_9) return c - CH_0;
		if (c >= CH_UA && c <= CH_UF) return c - CH_UA + 10;
		if (c >= CH_LA && c <= CH_LF) return c - CH_LA + 10;
		return NOT_A_DIGIT;
	endfunction

	// Closes the current string with one result.
	function automatic bit finish_parse(input logic [31:0] v, input logic [31:0] off,
			input status_t st, output parse_result_t r);
		r.value = v;
		r.offset = off;
		r.status = st;
		phase = PH_IDLE;
		return 1'b1;
	endfunction

	// Digit phase: a non-digit ends the string, an overflowing digit saturates.
	function automatic bit accumulate(input logic [7:0] c, output parse_result_t r);
		longint unsigned d, lim;
		d = digit_value(c);
		if (d >= ebase) return finish_parse(neg ? 32'd0 - acc : acc, count, ST_OK, r);
		if (cfg_signed) lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		else lim = 64'hFFFF_FFFF;
		if (acc > (lim - d) / ebase)
			return finish_parse((cfg_signed && neg) ? 32'h8000_0000 : lim[31:0], '0,
				ST_RANGE, r);
		acc = 32'(acc * ebase + d);
		return 1'b0;
	endfunction

	// First character after white space and the optional sign.
	function automatic bit start_number(input logic [7:0] c, output parse_result_t r);
		if (c == CH_0) begin
			phase = PH_ZERO;
			return 1'b0;
		end
		ebase = (cfg_base == BASE_AUTO) ? BASE_DEC : cfg_base;
		phase = PH_DIGITS;
		return accumulate(c, r);
	endfunction

	// Advances the predicted parser by one item; returns 1 when a result is due.
	function automatic bit parse_step(input logic [7:0] c, input bit first,
			output parse_result_t r);
		bit got = 1'b0;
		if (first) begin
			phase = PH_LEAD;
			acc = '0;
			neg = 1'b0;
			ebase = 0;
			count = '0;
		end else if (phase == PH_IDLE) begin
			return 1'b0;
		end else begin
			count = count + 1;
		end
		case (phase)
			PH_LEAD: begin
				if (!is_blank(c)) begin
					if (c == CH_PLUS || c == CH_MINUS) begin
						neg = (c == CH_MINUS) && cfg_signed;
						phase = PH_SIGN;
					end else begin
						got = start_number(c, r);
					end
				end
			end
			PH_SIGN: got = start_number(c, r);
			PH_ZERO: begin
				if (c == CH_LX || c == CH_UX) begin
					if (cfg_base != BASE_AUTO && cfg_base != BASE_HEX) begin
						got = finish_parse('0, '0, ST_BAD_PREFIX, r);
					end else begin
						ebase = BASE_HEX;
						phase = PH_DIGITS;
					end
				end else begin
					ebase = (cfg_base == BASE_AUTO) ? BASE_OCT : cfg_base;
					acc = '0;
					phase = PH_DIGITS;
					got = accumulate(c, r);
				end
			end
			PH_DIGITS: got = accumulate(c, r);
			default: phase = PH_IDLE;
		endcase
		return got;
	endfunction

	// Queues one string; the first flag goes on its first item when asked.
	function automatic void queue_text(input logic [7:0] text[$], input bit restart,
			input bit typed, input parse_result_t want);
		foreach (text[i]) char_queue.push_back('{text[i], restart && i == 0, typed, want});
	endfunction

	// Queues one random string and returns how many of its items count.
	function automatic int unsigned queue_random_text();
		logic [7:0] text[$];
		logic [7:0] digits[$];
		longint unsigned v, d;
		int unsigned b, kind, pick;
		bit upper;
		kind = $urandom_range(99);
		upper = 1'($urandom_range(1));
		if (kind >= 90) begin
			// Stray items without a first flag: they extend an open string or are ignored.
			repeat ($urandom_range(1, 3)) text.push_back(8'($urandom));
			queue_text(text, 1'b0, 1'b0, '0);
			return 0;
		end
		if (kind >= 80) begin
			repeat ($urandom_range(1, 6)) text.push_back(8'($urandom));
			queue_text(text, 1'b1, 1'b0, '0);
			return text.size();
		end
		// Well-formed number: blanks, sign, prefix, digits, terminator.
		repeat ($urandom_range(3)) begin
			pick = $urandom_range(5);
			text.push_back(pick == 5 ? CH_SPACE : CH_TAB + 8'(pick));
		end
		case ($urandom_range(2))
			1: text.push_back(CH_PLUS);
			2: text.push_back(CH_MINUS);
			default: ;
		endcase
		if (cfg_base == BASE_AUTO) begin
			case ($urandom_range(2))
				0: b = BASE_DEC;
				1: begin
					b = BASE_OCT;
					text.push_back(CH_0);
				end
				default: begin
					b = BASE_HEX;
					text.push_back(CH_0);
					text.push_back($urandom_range(1) ? CH_LX : CH_UX);
				end
			endcase
		end else begin
			// A hex prefix is also tried now and then where it is a bad prefix.
			if ($urandom_range(9) == 0 || (cfg_base == BASE_HEX && $urandom_range(1))) begin
				text.push_back(CH_0);
				text.push_back($urandom_range(1) ? CH_LX : CH_UX);
			end
			b = (cfg_base > BASE_HEX) ? BASE_HEX : cfg_base;
		end
		case ($urandom_range(3))
			0: v = 64'($urandom_range(999));
			1: v = 64'($urandom);
			2: v = ($urandom_range(1) ? 64'h8000_0000 : 64'h1_0000_0000) - 2 + $urandom_range(3);
			default: v = {$urandom, $urandom};
		endcase
		if (b == 1) begin
			repeat ($urandom_range(1, 4)) text.push_back(CH_0);
		end else begin
			do begin
				d = v % b;
				digits.push_front(d < 10 ? CH_0 + 8'(d) : (upper ? CH_UA : CH_LA) + 8'(d - 10));
				v = v / b;
			end while (v != 0);
			foreach (digits[i]) text.push_back(digits[i]);
		end
		// Some strings are cut off by the next first flag instead of a terminator.
		if (kind < 70) text.push_back($urandom_range(3) == 0 ? 8'($urandom) : 8'h00);
		queue_text(text, 1'b1, 1'b0, '0);
		return text.size();
	endfunction

	function automatic void add_row(input string chars, input logic [7:0] tail,
			input logic [4:0] base, input bit sgn, input bit restart, input bit typed,
			input logic [31:0] value, input logic [31:0] offset, input status_t st);
		directed_rows.push_back('{chars, tail, base, sgn, restart, typed, value, offset, st});
	endfunction

	// Waits until every item is accepted and every result has come, then lets
	// the pipeline settle.
	task automatic wait_idle();
		while (char_queue.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register access: setup phase, then access phase held until pready.
	task automatic reg_access(input logic idx, input bit wr, input logic [PDATA_W-1:0] data,
			output logic [PDATA_W-1:0] rd);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Writes both registers while the block is idle and reads them back.
	task automatic configure(input logic [4:0] base, input bit sgn);
		logic [PDATA_W-1:0] rd;
		wait_idle();
		reg_access(REG_NUMBER_BASE, 1'b1, PDATA_W'(base), rd);
		reg_access(REG_SIGNED_MODE, 1'b1, PDATA_W'(sgn), rd);
		cfg_base = base;
		cfg_signed = sgn;
		config_writes += 2;
		reg_access(REG_NUMBER_BASE, 1'b0, '0, rd);
		if (rd !== PDATA_W'(base)) begin
			$error("prdata number_base: expected %h, got %h", PDATA_W'(base), rd);
			fail_count++;
		end
		reg_access(REG_SIGNED_MODE, 1'b0, '0, rd);
		if (rd !== PDATA_W'(sgn)) begin
			$error("prdata signed_mode: expected %h, got %h", PDATA_W'(sgn), rd);
			fail_count++;
		end
	endtask

	// Sender and receiver pacing; inputs change on the falling edge.
	always @(negedge clk) begin
		if (arst_n && (in_taken || !in_valid)) begin
			in_taken = 1'b0;
			if (char_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cur_byte = char_queue.pop_front();
				in_valid <= 1'b1;
				char_in <= cur_byte.ch;
				first_char <= cur_byte.first;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// Predicts on every accepted item and checks every accepted result.
	always @(posedge clk) begin : monitor
		parse_result_t got;
		parse_result_t want;
		bit moved;
		moved = psel;
		if (arst_n && in_valid && in_ready) begin
			moved = 1'b1;
			in_taken = 1'b1;
			items_accepted++;
			if (first_char) begin
				typed_pending = cur_byte.typed;
				typed_result = cur_byte.want;
			end
			if (parse_step(char_in, first_char, got)) begin
				if (typed_pending) begin
					got = typed_result;
					typed_pending = 1'b0;
				end
				expected_results.push_back(got);
			end
		end
		if (arst_n && out_valid && out_ready) begin
			moved = 1'b1;
			results_checked++;
			if (expected_results.size() == 0) begin
				$error("unexpected result: value_out %h end_offset %h status %0d",
					value_out, end_offset, status);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (value_out !== want.value) begin
					$error("value_out: expected %h, got %h", want.value, value_out);
					fail_count++;
				end
				if (end_offset !== want.offset) begin
					$error("end_offset: expected %0d, got %0d", want.offset, end_offset);
					fail_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
			end
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
	end

	// Ends a run that has stopped moving.
	always @(negedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no item or result moved for %0d cycles.", WATCHDOG_LIMIT);
			$display("tb_parse_integer_text NOT OK");
			$finish;
		end
	end

	initial begin
		logic [7:0] text[$];
		bit configured;
		int unsigned phase_items;
		configured = 1'b0;

		// Directed strings; rows with a typed result bypass the predictor.
		add_row("0", 8'h00, BASE_AUTO, 1, 1, 1, 32'd0, 32'd1, ST_OK);
		add_row("  -2147483648", 8'h00, BASE_DEC, 1, 1, 1, 32'h8000_0000, 32'd13, ST_OK);
		add_row("2147483648", 8'h00, BASE_DEC, 1, 1, 1, 32'h7FFF_FFFF, 32'd0, ST_RANGE);
		add_row("-2147483649", 8'h00, BASE_DEC, 1, 1, 1, 32'h8000_0000, 32'd0, ST_RANGE);
		add_row("99", 8'h00, BASE_DEC, 1, 0, 0, '0, '0, ST_OK);
		add_row("4294967295", 8'h00, BASE_DEC, 0, 1, 1, 32'hFFFF_FFFF, 32'd10, ST_OK);
		add_row("4294967296", 8'h00, BASE_DEC, 0, 1, 1, 32'hFFFF_FFFF, 32'd0, ST_RANGE);
		add_row("-2147483648", 8'h00, BASE_DEC, 0, 1, 1, 32'h8000_0000, 32'd11, ST_OK);
		add_row("-5", 8'h00, BASE_DEC, 0, 1, 1, 32'd5, 32'd2, ST_OK);
		add_row("0x1f", 8'h00, BASE_DEC, 0, 1, 1, 32'd0, 32'd0, ST_BAD_PREFIX);
		add_row("0X", 8'h00, BASE_AUTO, 1, 1, 1, 32'd0, 32'd2, ST_OK);
		add_row("0777", 8'h00, BASE_AUTO, 1, 1, 1, 32'd511, 32'd4, ST_OK);
		add_row("089", 8'h00, BASE_AUTO, 1, 1, 1, 32'd0, 32'd1, ST_OK);
		add_row("-0x10", 8'h00, BASE_AUTO, 1, 1, 1, 32'hFFFF_FFF0, 32'd5, ST_OK);
		add_row("+-1", 8'h00, BASE_AUTO, 1, 1, 1, 32'd0, 32'd1, ST_OK);
		add_row("\t\n\013\014\015 12", 8'h7A, BASE_AUTO, 1, 1, 0, '0, '0, ST_OK);
		add_row("1", 8'h32, BASE_AUTO, 1, 1, 0, '0, '0, ST_OK);
		add_row("0xFFFFFFFF", 8'h00, BASE_HEX, 0, 1, 1, 32'hFFFF_FFFF, 32'd10, ST_OK);
		add_row("0xfFaA09", 8'hFF, BASE_HEX, 1, 1, 0, '0, '0, ST_OK);
		add_row("7fffffff", 8'h00, BASE_HEX, 1, 1, 1, 32'h7FFF_FFFF, 32'd8, ST_OK);
		add_row("80000000", 8'h00, BASE_HEX, 1, 1, 1, 32'h7FFF_FFFF, 32'd0, ST_RANGE);
		add_row("1010", 8'h00, 5'd2, 0, 1, 1, 32'd10, 32'd4, ST_OK);
		add_row("00", 8'h00, 5'd1, 1, 1, 1, 32'd0, 32'd2, ST_OK);
		add_row("1", 8'h00, 5'd1, 1, 1, 1, 32'd0, 32'd0, ST_OK);
		add_row("fF9aA", 8'h00, 5'd31, 0, 1, 0, '0, '0, ST_OK);

		// Reset, released on a falling edge.
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, registers rewritten whenever a row needs other settings.
		foreach (directed_rows[r]) begin
			if (!configured || directed_rows[r].base != cfg_base
					|| directed_rows[r].sgn != cfg_signed) begin
				configure(directed_rows[r].base, directed_rows[r].sgn);
				configured = 1'b1;
			end
			text.delete();
			for (int i = 0; i < directed_rows[r].chars.len(); i++)
				text.push_back(directed_rows[r].chars[i]);
			text.push_back(directed_rows[r].tail);
			queue_text(text, directed_rows[r].restart, directed_rows[r].typed,
				'{directed_rows[r].value, directed_rows[r].offset, directed_rows[r].status});
		end

		// Random part: every pacing mode under three register settings.
		for (int m = 0; m < 4; m++) begin
			for (int k = 0; k < 3; k++) begin
				configure(RAND_BASES[m*3+k], RAND_SIGNED[m*3+k]);
				send_idle_pct = SEND_IDLE[m];
				recv_stall_pct = RECV_STALL[m];
				phase_items = 0;
				while (phase_items < RANDOM_ITEMS / RANDOM_PHASES)
					phase_items += queue_random_text();
			end
		end

		wait_idle();
		$display("Accepted %0d text items and checked %0d results under %0d register writes,",
			items_accepted, results_checked, config_writes);
		$display("across radix 0 to 31, both sign modes and four pacing modes.");
		if (fail_count == 0) begin
			$display("tb_parse_integer_text OK");
		end else begin
			$display("tb_parse_integer_text NOT OK");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/pit_pkg.sv
src/pit_regs.sv
src/pit_classify.sv
src/pit_core.sv
src/parse_integer_text.sv
test/tb_parse_integer_text.sv
